[hdl/line_pair_closest_approach_macros.svh]
// assertion macros for the line pair closest approach block
// used by the top level only; expects clk and arst_n in scope
`ifndef LINE_PAIR_CLOSEST_APPROACH_MACROS_SVH
`define LINE_PAIR_CLOSEST_APPROACH_MACROS_SVH

// same-cycle implication
`define LPCA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpca: implication check failed");

// next-cycle implication
`define LPCA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpca: next-cycle check failed");

`endif

[hdl/lpca_pkg.sv]
// shared types and constants for the line pair closest approach block
// no dependencies
`timescale 1ns / 1ps

package lpca_pkg;

	localparam int LPCA_FRAC_BITS   = 16;
	localparam int LPCA_QUEUE_DEPTH = 8;
	localparam int LPCA_WW          = 224;
	localparam logic [31:0] LPCA_THR_RESET = 32'd1;

	typedef struct packed {
		logic signed [31:0] first_origin_x;
		logic signed [31:0] first_origin_y;
		logic signed [31:0] first_origin_z;
		logic signed [31:0] first_direction_x;
		logic signed [31:0] first_direction_y;
		logic signed [31:0] first_direction_z;
		logic signed [31:0] second_origin_x;
		logic signed [31:0] second_origin_y;
		logic signed [31:0] second_origin_z;
		logic signed [31:0] second_direction_x;
		logic signed [31:0] second_direction_y;
		logic signed [31:0] second_direction_z;
	} lpca_req_t;

	typedef struct packed {
		logic [31:0]        separation;
		logic signed [31:0] nearest_x;
		logic signed [31:0] nearest_y;
		logic signed [31:0] nearest_z;
		logic               is_parallel;
		logic               is_degenerate;
	} lpca_rsp_t;

	// first line, origin offset, and dot and cross products of one pair, all exact
	typedef struct packed {
		logic [2:0][31:0] o1;
		logic [2:0][31:0] d1;
		logic [2:0][32:0] dp;
		logic [63:0]      a;
		logic [63:0]      b;
		logic [65:0]      c;
		logic [66:0]      e;
		logic [66:0]      f;
		logic [2:0][64:0] v;
		logic [2:0][65:0] u;
	} lpca_job_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MAG0,
		ST_MAG1,
		ST_MAG2,
		ST_CLS,
		ST_NUM0,
		ST_NUM1,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_MM,
		ST_DIV,
		ST_SQRT,
		ST_NMUL,
		ST_NDIV,
		ST_NFIN,
		ST_U0,
		ST_U1,
		ST_U2,
		ST_DONE
	} lpca_state_t;

endpackage

[hdl/line_pair_closest_approach.sv]
// Closest approach of two 3D lines in signed fixed point. Line pairs enter a
// three-stage product front end that feeds an eight-entry job queue, so pairs
// are taken back to back until the queue and front end hold eight jobs. The back
// end works one job at a time, with a bit-serial multiply-accumulate unit, a
// restoring divider and a square root unit, one bit per cycle each. A multiply
// runs until its multiplier has no bits left, so the time per job follows the
// operand sizes. A zero first direction skips the divides and the root. The
// divides take 64 and 33 steps and the root 32 steps. Sustained throughput is
// one pair per back end job. Results come out in order through an output
// register. The user must see that parallel_threshold is written through
// cfg_we and cfg_wdata while idle; the block itself does not enforce this.
// Depends on lpca_pkg, lpca_queue, lpca_front, lpca_back and the macro header.
`timescale 1ns / 1ps
`include "line_pair_closest_approach_macros.svh"

module line_pair_closest_approach
	import lpca_pkg::*;
#(
	parameter int FRACTION_BITS = LPCA_FRAC_BITS,
	parameter int QUEUE_DEPTH   = LPCA_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  lpca_req_t   req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output lpca_rsp_t   rsp_data
);

	logic [31:0]                      thr_q;
	logic                             push, pop, head_valid;
	lpca_job_t                        push_data, head_data;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	logic                             rsp_point_zero;
	logic                             rsp_sep_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= LPCA_THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	lpca_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	lpca_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.count      (q_count)
	);

	lpca_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr        (thr_q),
		.head_valid (head_valid),
		.job        (head_data),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data)
	);

	assign rsp_point_zero = (rsp_data.nearest_x == '0) && (rsp_data.nearest_y == '0) &&
		(rsp_data.nearest_z == '0);
	assign rsp_sep_max = (rsp_data.separation == 32'hFFFF_FFFF);

	`LPCA_ASSERT_IMP(a_par_point_zero, rsp_valid && rsp_data.is_parallel, rsp_point_zero)
	`LPCA_ASSERT_IMP(a_degen_sat, rsp_valid && rsp_data.is_degenerate, rsp_data.is_parallel && rsp_sep_max)
	`LPCA_ASSERT_NXT(a_thr_write, cfg_we, thr_q == $past(cfg_wdata))

endmodule

[hdl/lpca_queue.sv]
// job queue between the product front end and the solver back end
// depends on lpca_pkg
`timescale 1ns / 1ps

module lpca_queue
	import lpca_pkg::*;
#(
	parameter int DEPTH = LPCA_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  lpca_job_t                  push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output lpca_job_t                  head_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lpca_job_t         mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/lpca_front.sv]
// front end: takes line pairs and forms all dot and cross products in three stages
// depends on lpca_pkg; pushes finished jobs into lpca_queue
`timescale 1ns / 1ps

module lpca_front
	import lpca_pkg::*;
#(
	parameter int DEPTH = LPCA_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  lpca_req_t                  req_data,
	input  logic [$clog2(DEPTH+1)-1:0] q_count,
	output logic                       push,
	output lpca_job_t                  push_data
);

	localparam int OW = $clog2(DEPTH + 4);

	logic              valid_s1, valid_s2, valid_s3;
	logic              take;
	logic [OW-1:0]     occ;

	lpca_req_t         req_s1;
	logic signed [32:0] dp_s1 [3];
	logic signed [31:0] o1 [3];
	logic signed [31:0] d1 [3];
	logic signed [31:0] d2 [3];

	logic signed [31:0] o1_s2 [3];
	logic signed [31:0] d1_s2 [3];
	logic signed [32:0] dp_s2 [3];
	logic signed [65:0] aa_s2 [3];
	logic signed [65:0] bb_s2 [3];
	logic signed [65:0] cc_s2 [3];
	logic signed [65:0] ee_s2 [3];
	logic signed [65:0] ff_s2 [3];
	logic signed [65:0] pv1_s2 [3];
	logic signed [65:0] pv2_s2 [3];
	logic signed [65:0] pu1_s2 [3];
	logic signed [65:0] pu2_s2 [3];

	lpca_job_t         job_s3;
	lpca_job_t         job_d;
	logic signed [65:0] a_sum, b_sum, c_sum;
	logic signed [66:0] e_sum, f_sum;

	// every beat in flight already owns a queue slot
	assign occ = OW'(q_count) + OW'(valid_s1) + OW'(valid_s2) + OW'(valid_s3);
	assign req_stall = (occ >= OW'(DEPTH));
	assign take = req_valid && !req_stall;

	assign o1[0] = req_s1.first_origin_x;
	assign o1[1] = req_s1.first_origin_y;
	assign o1[2] = req_s1.first_origin_z;
	assign d1[0] = req_s1.first_direction_x;
	assign d1[1] = req_s1.first_direction_y;
	assign d1[2] = req_s1.first_direction_z;
	assign d2[0] = req_s1.second_direction_x;
	assign d2[1] = req_s1.second_direction_y;
	assign d2[2] = req_s1.second_direction_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1   <= req_data;
			dp_s1[0] <= 33'(req_data.second_origin_x) - 33'(req_data.first_origin_x);
			dp_s1[1] <= 33'(req_data.second_origin_y) - 33'(req_data.first_origin_y);
			dp_s1[2] <= 33'(req_data.second_origin_z) - 33'(req_data.first_origin_z);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_prod
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			o1_s2[i]  <= o1[i];
			d1_s2[i]  <= d1[i];
			dp_s2[i]  <= dp_s1[i];
			aa_s2[i]  <= d1[i] * d1[i];
			bb_s2[i]  <= d2[i] * d2[i];
			cc_s2[i]  <= d1[i] * d2[i];
			ee_s2[i]  <= dp_s1[i] * d1[i];
			ff_s2[i]  <= dp_s1[i] * d2[i];
			pv1_s2[i] <= d1[J] * d2[K];
			pv2_s2[i] <= d1[K] * d2[J];
			pu1_s2[i] <= dp_s1[J] * d1[K];
			pu2_s2[i] <= dp_s1[K] * d1[J];
		end
	end

	always_comb begin
		a_sum = aa_s2[0] + aa_s2[1] + aa_s2[2];
		b_sum = bb_s2[0] + bb_s2[1] + bb_s2[2];
		c_sum = cc_s2[0] + cc_s2[1] + cc_s2[2];
		e_sum = 67'(ee_s2[0]) + 67'(ee_s2[1]) + 67'(ee_s2[2]);
		f_sum = 67'(ff_s2[0]) + 67'(ff_s2[1]) + 67'(ff_s2[2]);
		job_d.a = a_sum[63:0];
		job_d.b = b_sum[63:0];
		job_d.c = c_sum;
		job_d.e = e_sum;
		job_d.f = f_sum;
		for (int i = 0; i < 3; i++) begin
			job_d.o1[i] = o1_s2[i];
			job_d.d1[i] = d1_s2[i];
			job_d.dp[i] = dp_s2[i];
			job_d.v[i]  = 65'(pv1_s2[i] - pv2_s2[i]);
			job_d.u[i]  = pu1_s2[i] - pu2_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		job_s3 <= job_d;
	end

	assign push      = valid_s3;
	assign push_data = job_s3;

endmodule

[hdl/lpca_back.sv]
// back end: bit-serial multiply-accumulate, divide and square root sequencer
// depends on lpca_pkg; reads jobs from lpca_queue and holds the result register
`timescale 1ns / 1ps

module lpca_back
	import lpca_pkg::*;
#(
	parameter int FRACTION_BITS = LPCA_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] thr,
	input  logic        head_valid,
	input  lpca_job_t   job,
	output logic        pop,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output lpca_rsp_t   rsp_data
);

	localparam int WW        = LPCA_WW;
	localparam int THR_SHIFT = 3 * FRACTION_BITS;

	lpca_state_t       state_q, state_d;

	logic              run_q;
	logic [WW-1:0]     x_q, y_q, acc_q;
	logic              neg_q;
	logic [WW-1:0]     mag_q, num_q, m_q;
	logic [WW-1:0]     rem_q, dsr_q;
	logic [63:0]       lo_q, quot_q;
	logic [6:0]        cnt_q;
	logic [63:0]       rad_q;
	logic [31:0]       root_q;
	logic [4:0]        bit_q;
	logic [31:0]       sep_q;
	logic [31:0]       near_q [3];
	logic              par_q, deg_q, nneg_q;
	logic [1:0]        idx_q;
	logic              rsp_valid_q;
	lpca_rsp_t         rsp_q;

	logic              mac_state, mac_done;
	logic [WW-1:0]     sel_x, sel_y, y_mag;
	logic              sel_sub, sel_clr, sel_neg;
	logic              crossing, sat_mm, sat_u, cap_n;
	logic [WW-1:0]     n_abs;
	logic [WW-1:0]     div_t, div_r;
	logic              div_ge;
	logic [31:0]       cand, root_nx;
	logic [63:0]       cand_sq;
	logic signed [35:0] t_val, r_val;
	logic [35:0]       q_ext;
	logic [31:0]       coord;
	logic              out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		sel_x   = '0;
		sel_y   = '0;
		sel_sub = 1'b0;
		sel_clr = 1'b0;
		mac_state = 1'b1;
		case (state_q)
			ST_MAG0: begin sel_x = WW'($signed(job.v[0])); sel_y = sel_x; sel_clr = 1'b1; end
			ST_MAG1: begin sel_x = WW'($signed(job.v[1])); sel_y = sel_x; end
			ST_MAG2: begin sel_x = WW'($signed(job.v[2])); sel_y = sel_x; end
			ST_NUM0: begin
				sel_x = WW'($signed(job.f)); sel_y = WW'($signed(job.c)); sel_clr = 1'b1;
			end
			ST_NUM1: begin sel_x = WW'($signed(job.e)); sel_y = WW'(job.b); sel_sub = 1'b1; end
			ST_M0: begin
				sel_x = WW'($signed(job.v[0])); sel_y = WW'($signed(job.dp[0])); sel_clr = 1'b1;
			end
			ST_M1: begin sel_x = WW'($signed(job.v[1])); sel_y = WW'($signed(job.dp[1])); end
			ST_M2: begin sel_x = WW'($signed(job.v[2])); sel_y = WW'($signed(job.dp[2])); end
			ST_MM: begin sel_x = m_q; sel_y = m_q; sel_clr = 1'b1; end
			ST_NMUL: begin
				sel_x = num_q; sel_y = WW'($signed(job.d1[idx_q])); sel_clr = 1'b1;
			end
			ST_U0: begin sel_x = WW'($signed(job.u[0])); sel_y = sel_x; sel_clr = 1'b1; end
			ST_U1: begin sel_x = WW'($signed(job.u[1])); sel_y = sel_x; end
			ST_U2: begin sel_x = WW'($signed(job.u[2])); sel_y = sel_x; end
			default: mac_state = 1'b0;
		endcase
		y_mag   = sel_y[WW-1] ? (~sel_y + 1'b1) : sel_y;
		sel_neg = sel_y[WW-1] ^ sel_sub;
	end

	assign mac_done = mac_state && run_q && (y_q == '0);

	assign crossing = mag_q > (WW'(thr) << THR_SHIFT);
	assign sat_mm   = acc_q >= (mag_q << 64);
	assign sat_u    = acc_q >= (WW'(job.a) << 64);
	assign n_abs    = acc_q[WW-1] ? (~acc_q + 1'b1) : acc_q;
	assign cap_n    = n_abs >= (mag_q << 33);

	// restoring divide, one quotient bit a cycle
	assign div_t  = {rem_q[WW-2:0], lo_q[63]};
	assign div_ge = div_t >= dsr_q;
	assign div_r  = div_ge ? (div_t - dsr_q) : div_t;

	// square root, one result bit a cycle
	assign cand    = root_q | (32'd1 << bit_q);
	assign cand_sq = cand * cand;
	assign root_nx = (cand_sq <= rad_q) ? cand : root_q;

	// nearest coordinate: quotient is at most 2^33, so 36 bits cover the sum
	always_comb begin
		q_ext = {1'b0, quot_q[34:0]};
		t_val = nneg_q ? $signed(q_ext) : -$signed(q_ext);
		r_val = 36'($signed(job.o1[idx_q])) + t_val;
		if (r_val > 36'sd2147483647) begin
			coord = 32'h7FFF_FFFF;
		end else if (r_val < -36'sd2147483648) begin
			coord = 32'h8000_0000;
		end else begin
			coord = r_val[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			ST_IDLE: if (head_valid) state_d = ST_MAG0;
			ST_MAG0: if (mac_done) state_d = ST_MAG1;
			ST_MAG1: if (mac_done) state_d = ST_MAG2;
			ST_MAG2: if (mac_done) state_d = ST_CLS;
			ST_CLS: begin
				if (crossing) begin
					state_d = ST_NUM0;
				end else if (job.a == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_U0;
				end
			end
			ST_NUM0: if (mac_done) state_d = ST_NUM1;
			ST_NUM1: if (mac_done) state_d = ST_M0;
			ST_M0: if (mac_done) state_d = ST_M1;
			ST_M1: if (mac_done) state_d = ST_M2;
			ST_M2: if (mac_done) state_d = ST_MM;
			ST_MM: if (mac_done) state_d = sat_mm ? ST_NMUL : ST_DIV;
			ST_DIV: if (cnt_q == '0) state_d = ST_SQRT;
			ST_SQRT: if (bit_q == '0) state_d = par_q ? ST_DONE : ST_NMUL;
			ST_NMUL: if (mac_done) state_d = cap_n ? ST_NFIN : ST_NDIV;
			ST_NDIV: if (cnt_q == '0) state_d = ST_NFIN;
			ST_NFIN: state_d = (idx_q == 2'd2) ? ST_DONE : ST_NMUL;
			ST_U0: if (mac_done) state_d = ST_U1;
			ST_U1: if (mac_done) state_d = ST_U2;
			ST_U2: if (mac_done) state_d = sat_u ? ST_DONE : ST_DIV;
			ST_DONE: begin
				if (out_free) begin
					pop     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mac_state) begin
				run_q <= !mac_done;
			end
			if (pop) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		// multiply-accumulate: load, then one multiplier bit a cycle
		if (mac_state) begin
			if (!run_q) begin
				x_q   <= sel_x;
				y_q   <= y_mag;
				neg_q <= sel_neg;
				if (sel_clr) begin
					acc_q <= '0;
				end
			end else if (y_q != '0) begin
				if (y_q[0]) begin
					acc_q <= neg_q ? (acc_q - x_q) : (acc_q + x_q);
				end
				x_q <= x_q << 1;
				y_q <= y_q >> 1;
			end
		end

		case (state_q)
			ST_IDLE: begin
				idx_q <= '0;
			end
			ST_MAG2: if (mac_done) mag_q <= acc_q;
			ST_CLS: begin
				par_q <= !crossing;
				deg_q <= !crossing && (job.a == '0);
				if (!crossing) begin
					for (int i = 0; i < 3; i++) begin
						near_q[i] <= '0;
					end
					if (job.a == '0) begin
						sep_q <= '1;
					end
				end
			end
			ST_NUM1: if (mac_done) num_q <= acc_q;
			ST_M2: if (mac_done) m_q <= acc_q;
			ST_MM, ST_U2: begin
				if (mac_done) begin
					if ((state_q == ST_MM) ? sat_mm : sat_u) begin
						sep_q <= '1;
					end
					rem_q  <= acc_q >> 64;
					lo_q   <= acc_q[63:0];
					dsr_q  <= (state_q == ST_MM) ? mag_q : WW'(job.a);
					cnt_q  <= 7'd64;
					quot_q <= '0;
				end
			end
			ST_DIV, ST_NDIV: begin
				if (cnt_q != '0) begin
					rem_q  <= div_r;
					lo_q   <= lo_q << 1;
					quot_q <= {quot_q[62:0], div_ge};
					cnt_q  <= cnt_q - 1'b1;
				end else if (state_q == ST_DIV) begin
					rad_q  <= quot_q;
					root_q <= '0;
					bit_q  <= 5'd31;
				end
			end
			ST_SQRT: begin
				root_q <= root_nx;
				bit_q  <= bit_q - 1'b1;
				if (bit_q == '0) begin
					sep_q <= root_nx;
				end
			end
			ST_NMUL: begin
				if (mac_done) begin
					nneg_q <= acc_q[WW-1];
					if (cap_n) begin
						quot_q <= 64'd1 << 33;
					end else begin
						rem_q  <= n_abs >> 33;
						lo_q   <= {n_abs[32:0], 31'd0};
						dsr_q  <= mag_q;
						cnt_q  <= 7'd33;
						quot_q <= '0;
					end
				end
			end
			ST_NFIN: begin
				near_q[idx_q] <= coord;
				idx_q         <= idx_q + 1'b1;
			end
			default: ;
		endcase

		if (pop) begin
			rsp_q.separation    <= sep_q;
			rsp_q.nearest_x     <= near_q[0];
			rsp_q.nearest_y     <= near_q[1];
			rsp_q.nearest_z     <= near_q[2];
			rsp_q.is_parallel   <= par_q;
			rsp_q.is_degenerate <= deg_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[tb/line_pair_closest_approach_test.sv]
// testbench for line_pair_closest_approach: drives line pairs, checks each result
// against an exact 256-bit predictor of the closest approach arithmetic
// depends on lpca_pkg and the line_pair_closest_approach rtl
`timescale 1ns / 1ps

module line_pair_closest_approach_test;
	import lpca_pkg::*;

	typedef logic signed [255:0] wide_t;
	typedef logic [255:0] uwide_t;

	localparam int UNIT = 1 << LPCA_FRAC_BITS;
	localparam int I32_MAX = 32'h7fffffff;
	localparam int I32_MIN = 32'h80000000;
	localparam int LONG_HOLD = 3000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	logic req_valid;
	logic req_stall;
	lpca_req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	lpca_rsp_t rsp_data;

	lpca_req_t pending_pairs[$];
	lpca_rsp_t expected_answers[$];
	logic [31:0] threshold_copy;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int holds_served;
	int hold_left;
	bit req_took;
	int mismatches;
	int pairs_sent;
	int answers_seen;
	int parallel_seen;
	int degenerate_seen;

	line_pair_closest_approach dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic wide_t dot3(wide_t x[3], wide_t y[3]);
		return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
	endfunction

	function automatic void cross3(input wide_t x[3], input wide_t y[3], output wide_t o[3]);
		o[0] = x[1] * y[2] - x[2] * y[1];
		o[1] = x[2] * y[0] - x[0] * y[2];
		o[2] = x[0] * y[1] - x[1] * y[0];
	endfunction

	function automatic logic [31:0] root_clamped(uwide_t x);
		uwide_t root;
		uwide_t cand;
		root = '0;
		for (int bitpos = 127; bitpos >= 0; bitpos--) begin
			cand = root | (uwide_t'(1) << bitpos);
			if (cand * cand <= x)
				root = cand;
		end
		return (root > uwide_t'(32'hffffffff)) ? 32'hffffffff : root[31:0];
	endfunction

	function automatic logic [31:0] clamp_s32(wide_t x);
		if (x > wide_t'(I32_MAX))
			return 32'h7fffffff;
		if (x < wide_t'(I32_MIN))
			return 32'h80000000;
		return x[31:0];
	endfunction

	// exact closest approach of one pair under the current threshold
	function automatic lpca_rsp_t closest_approach(lpca_req_t p, logic [31:0] thr_reg);
		wide_t o1[3], d1[3], o2[3], d2[3], dp[3], v[3], near_pt[3];
		wide_t a, b, c, e, f, det, mag, thr, num, m;
		lpca_rsp_t r;
		o1 = '{p.first_origin_x, p.first_origin_y, p.first_origin_z};
		d1 = '{p.first_direction_x, p.first_direction_y, p.first_direction_z};
		o2 = '{p.second_origin_x, p.second_origin_y, p.second_origin_z};
		d2 = '{p.second_direction_x, p.second_direction_y, p.second_direction_z};
		for (int i = 0; i < 3; i++)
			dp[i] = o2[i] - o1[i];
		a = dot3(d1, d1);
		b = dot3(d2, d2);
		c = dot3(d1, d2);
		e = dot3(dp, d1);
		f = dot3(dp, d2);
		det = c * c - a * b;
		mag = (det < 0) ? -det : det;
		thr = wide_t'({224'd0, thr_reg}) << (3 * LPCA_FRAC_BITS);
		r = '0;
		if (mag > thr) begin
			num = c * f - b * e;
			for (int i = 0; i < 3; i++)
				near_pt[i] = o1[i] + (d1[i] * num) / det;
			r.nearest_x = clamp_s32(near_pt[0]);
			r.nearest_y = clamp_s32(near_pt[1]);
			r.nearest_z = clamp_s32(near_pt[2]);
			cross3(d1, d2, v);
			m = dot3(dp, v);
			r.separation = root_clamped(uwide_t'(m * m) / uwide_t'(mag));
		end else begin
			r.is_parallel = 1'b1;
			if (a == 0) begin
				r.is_degenerate = 1'b1;
				r.separation = 32'hffffffff;
			end else begin
				cross3(dp, d1, v);
				r.separation = root_clamped(uwide_t'(dot3(v, v)) / uwide_t'(a));
			end
		end
		return r;
	endfunction

	function automatic lpca_req_t make_pair(int ox, int oy, int oz, int dx, int dy, int dz,
			int px, int py, int pz, int ex, int ey, int ez);
		lpca_req_t p;
		p = '{ox, oy, oz, dx, dy, dz, px, py, pz, ex, ey, ez};
		return p;
	endfunction

	function automatic int small_coord();
		return int'($urandom_range(0, 1 << 21)) - (1 << 20);
	endfunction

	// random pair: raw bits, moderate skew, parallel, crossing, or zero first direction
	function automatic lpca_req_t random_pair();
		lpca_req_t p;
		int k;
		int shape;
		shape = $urandom_range(0, 9);
		p = make_pair(small_coord(), small_coord(), small_coord(), small_coord(),
			small_coord(), small_coord(), small_coord(), small_coord(), small_coord(),
			small_coord(), small_coord(), small_coord());
		case (shape)
			0, 1: begin
				p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			end
			2, 3: begin
				k = int'($urandom_range(0, 6)) - 3;
				p.second_direction_x = p.first_direction_x * k;
				p.second_direction_y = p.first_direction_y * k;
				p.second_direction_z = p.first_direction_z * k;
			end
			4: begin
				// second origin on the first line, so the lines meet
				p.second_origin_x = p.first_origin_x + p.first_direction_x;
				p.second_origin_y = p.first_origin_y + p.first_direction_y;
				p.second_origin_z = p.first_origin_z + p.first_direction_z;
			end
			5: begin
				p.first_direction_x = 0;
				p.first_direction_y = 0;
				p.first_direction_z = 0;
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (answer %0d)", what, got, want, answers_seen);
		mismatches++;
	endtask

	task automatic write_threshold(logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		threshold_copy = value;
	endtask

	// checked at rising edges, where the driven valid is settled
	task automatic wait_drained();
		while (pending_pairs.size() != 0 || expected_answers.size() != 0 || req_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		repeat (count) pending_pairs.push_back(random_pair());
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_took) begin
			req_took = 1'b0;
			if (pending_pairs.size() > 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
				req_data <= pending_pairs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with long holds counted here
	always @(negedge clk) begin
		if (holds_served < hold_requests) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= int'($urandom_range(0, 99)) < recv_idle_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		lpca_rsp_t want;
		if (arst_n && req_valid && !req_stall) begin
			expected_answers.push_back(closest_approach(req_data, threshold_copy));
			req_took = 1'b1;
			pairs_sent++;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			answers_seen++;
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected beat", rsp_data.separation, 32'd0);
			end else begin
				want = expected_answers.pop_front();
				parallel_seen += want.is_parallel;
				degenerate_seen += want.is_degenerate;
				if (rsp_data.separation !== want.separation)
					report_mismatch("separation", rsp_data.separation, want.separation);
				if (rsp_data.nearest_x !== want.nearest_x)
					report_mismatch("nearest_x", rsp_data.nearest_x, want.nearest_x);
				if (rsp_data.nearest_y !== want.nearest_y)
					report_mismatch("nearest_y", rsp_data.nearest_y, want.nearest_y);
				if (rsp_data.nearest_z !== want.nearest_z)
					report_mismatch("nearest_z", rsp_data.nearest_z, want.nearest_z);
				if (rsp_data.is_parallel !== want.is_parallel)
					report_mismatch("is_parallel", 32'(rsp_data.is_parallel),
						32'(want.is_parallel));
				if (rsp_data.is_degenerate !== want.is_degenerate)
					report_mismatch("is_degenerate", 32'(rsp_data.is_degenerate),
						32'(want.is_degenerate));
			end
		end
	end

	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_stall = 1'b0;
		req_took = 1'b0;
		threshold_copy = LPCA_THR_RESET;
		send_idle_pct = 27;
		recv_idle_pct = 57;
		hold_requests = 0;
		holds_served = 0;
		hold_left = 0;
		mismatches = 0;
		pairs_sent = 0;
		answers_seen = 0;
		parallel_seen = 0;
		degenerate_seen = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed pairs under the reset threshold
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(UNIT, 2, 3, 0, 0, 0, 5, 6, 7, UNIT, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, UNIT, 0, 0, 0, 0, UNIT, 0, UNIT, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, UNIT, 0, 0, 0, 3 * UNIT, 0, UNIT, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, UNIT, UNIT, 0, 0, 0, 0, 0, UNIT, UNIT));
		pending_pairs.push_back(make_pair(0, 0, 0, UNIT, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(I32_MAX, I32_MAX, I32_MAX, I32_MAX, I32_MAX,
			I32_MAX, I32_MAX, I32_MAX, I32_MAX, I32_MAX, I32_MAX, I32_MAX));
		pending_pairs.push_back(make_pair(I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN,
			I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN, I32_MIN));
		pending_pairs.push_back(make_pair(I32_MIN, I32_MAX, I32_MIN, I32_MAX, I32_MIN, 0,
			I32_MAX, I32_MIN, I32_MAX, 0, I32_MAX, I32_MIN));
		pending_pairs.push_back(make_pair(0, 0, I32_MIN, UNIT, 0, 0, 0, 0, I32_MAX,
			0, UNIT, 0));
		pending_pairs.push_back(make_pair(I32_MAX, 0, 0, 1, 0, 0, I32_MIN, 0, 0,
			0, 1, 1));
		pending_pairs.push_back(make_pair(0, 0, 0, 1, 1, 0, I32_MAX, I32_MIN, 0,
			I32_MAX, 0, I32_MIN));
		pending_pairs.push_back(make_pair(-1, -1, -1, -UNIT, UNIT, -UNIT, 1, 1, 1,
			UNIT, UNIT, -UNIT));
		wait_drained();

		// exact zero threshold: only exactly parallel lines count
		write_threshold(32'd0);
		pending_pairs.push_back(make_pair(0, 0, 0, UNIT, 0, 0, 0, UNIT, 0, 2 * UNIT, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, UNIT, 0, 0, 0, UNIT, 0, UNIT, 1, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, UNIT, 0, 1, 1, 0));
		pending_pairs.push_back(make_pair(5, 5, 5, 0, 0, 0, 7, 7, 7, 1, 0, 0));
		wait_drained();
		write_threshold(32'hffffffff);
		pending_pairs.push_back(make_pair(0, 0, 0, UNIT, 0, 0, 0, 0, UNIT, 0, UNIT, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, I32_MAX, 0, 0, 0, 0, UNIT, 0,
			I32_MAX, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, I32_MIN, 0, 0, 0, 0, UNIT, 0,
			I32_MIN, 0));
		wait_drained();

		write_threshold(32'd1);
		queue_random(300);
		wait_drained();

		// fill the block while the output is held off
		for (int i = 0; i < 20; i++)
			pending_pairs.push_back(make_pair(small_coord(), i, 0, 0, 0, 0,
				small_coord(), 0, i, small_coord(), 1, 0));
		queue_random(4);
		hold_requests++;
		wait_drained();

		write_threshold(32'd0);
		send_idle_pct = 57;
		recv_idle_pct = 27;
		queue_random(300);
		wait_drained();

		write_threshold(32'hffffffff);
		queue_random(80);
		wait_drained();

		write_threshold($urandom_range(2, 1 << 20));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(300);
		wait_drained();
		repeat (100) @(posedge clk);

		$display("line pairs sent %0d, answers checked %0d, parallel %0d, zero direction %0d",
			pairs_sent, answers_seen, parallel_seen, degenerate_seen);
		$display("thresholds 0, 1, max and random, with idling on both sides and a long hold");
		if (mismatches == 0 && expected_answers.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
